FILE: design/msst_pkg.sv
package msst_pkg;

    localparam int TICK_W   = 64;
    localparam int MS_W     = 32;
    localparam int PERIOD_W = 29;
    localparam int SLOT_W   = 3;
    localparam int MASK_W   = 8;
    localparam int MAX_EV   = 8;
    localparam int EV_CNT_W = 4;

    // ms / 10 via reciprocal: exact for every 32-bit value
    localparam logic [MS_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int              RECIP_SHIFT = 35;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_ONESHOT  = 2'd1,
        CMD_PERIODIC = 2'd2,
        CMD_STOP     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                start;
        logic [TICK_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] rem;
    } t_div_rsp;

endpackage

FILE: design/msst_if.sv
interface msst_cmd_if;
    import msst_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [SLOT_W-1:0]   timer_id;
    logic [MS_W-1:0]     period_ms;
    logic                notify;

    modport source (output valid, command, timer_id, period_ms, notify, input ready);
    modport sink   (input valid, command, timer_id, period_ms, notify, output ready);
endinterface

interface msst_res_if;
    import msst_pkg::*;
    logic                valid;
    logic                ready;
    logic                event_valid;
    logic [SLOT_W-1:0]   event_slot;
    logic                event_kind;
    logic                last;
    logic [MASK_W-1:0]   running_mask;
    logic                idle;

    modport source (output valid, event_valid, event_slot, event_kind, last, running_mask,
                    idle, input ready);
    modport sink   (input valid, event_valid, event_slot, event_kind, last, running_mask,
                    idle, output ready);
endinterface

FILE: design/msst_div.sv
module msst_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msst_pkg::t_div_req i_req,
    output msst_pkg::t_div_rsp o_rsp
);
    import msst_pkg::*;

    localparam int STEPS = TICK_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [TICK_W-1:0]   r_num;
    logic [PERIOD_W-1:0] r_div;
    logic [PERIOD_W-1:0] r_rem;
    logic                r_done;
    logic [PERIOD_W-1:0] n_rem1;
    logic [PERIOD_W-1:0] n_rem2;

    function automatic logic [PERIOD_W-1:0] rstep(input logic [PERIOD_W-1:0] rem,
                                                   input logic bit_in,
                                                   input logic [PERIOD_W-1:0] d);
        logic [PERIOD_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[PERIOD_W-1:0];
    endfunction

    always_comb begin
        n_rem1 = rstep(r_rem, r_num[TICK_W-1], r_div);
        n_rem2 = rstep(n_rem1, r_num[TICK_W-2], r_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[TICK_W-3:0], 2'b00};
            r_rem <= n_rem2;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: design/multi_slot_soft_timer.sv
// Sequencing: a start passes through S_START to S_EMIT, a stop goes straight to S_EMIT;
//   a tick walks every slot through S_TREAD and S_NEXT,
//   a running periodic slot also through S_TEVAL and S_TDIV (2-bit-per-cycle modulo unit),
//   a one-shot slot also through S_TEVAL; S_EMIT sends each result once the output is free.
// Throughput: one item at a time; a new command is accepted only in S_IDLE.
// Reset: synchronous active-low; clears tick count and slot flags. The
//   period/deadline memory is not cleared.
module multi_slot_soft_timer #(
    parameter int NUM_TIMERS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    msst_cmd_if.sink         i_cmd,
    msst_res_if.source       o_res
);
    import msst_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MW = PERIOD_W + TICK_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_TREAD = 7'b0000100,
        S_TEVAL = 7'b0001000,
        S_TDIV  = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state                r_state;
    logic [TICK_W-1:0]     r_tick;
    logic [NUM_TIMERS-1:0] r_run;
    logic [NUM_TIMERS-1:0] r_per;
    logic [NUM_TIMERS-1:0] r_ntf;
    logic [MW-1:0]         r_mem [NUM_TIMERS];
    logic [MW-1:0]         r_rd;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_id;
    t_cmd                  r_cmd;
    logic                  r_snotify;
    logic [2*MS_W-1:0]     r_prod;
    logic [SLOT_W-1:0]     r_evs [MAX_EV];
    logic                  r_evk [MAX_EV];
    logic [EV_CNT_W-1:0]   r_nev;
    logic [2:0]            r_eidx;
    logic                  r_fire;
    logic                  r_fkind;

    t_div_req              div_req;
    t_div_rsp              div_rsp;

    logic                  accept;
    logic                  out_free;
    logic                  in_range;
    logic [PERIOD_W-1:0]   q_ticks;
    logic [PERIOD_W-1:0]   rd_period;
    logic [TICK_W-1:0]     rd_deadline;
    logic [MASK_W-1:0]     mask;
    logic                  emit_last;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !o_res.valid || o_res.ready;
    assign in_range    = (32'(i_cmd.timer_id) < NUM_TIMERS);
    assign q_ticks     = r_prod[RECIP_SHIFT +: PERIOD_W];
    assign rd_period   = r_rd[MW-1 -: PERIOD_W];
    assign rd_deadline = r_rd[TICK_W-1:0];
    assign emit_last   = (r_nev == '0) || ({1'b0, r_eidx} == r_nev - 1'b1);

    always_comb begin
        mask = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < NUM_TIMERS) begin
                mask[i] = r_run[i];
            end
        end
    end

    assign div_req.start    = (r_state == S_TEVAL) && r_per[r_idx];
    assign div_req.dividend = r_tick;
    assign div_req.divisor  = rd_period;

    msst_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_START) begin
            if (r_cmd == CMD_ONESHOT) begin
                r_mem[r_id] <= {q_ticks, r_tick + TICK_W'(q_ticks)};
            end else begin
                r_mem[r_id] <= {((q_ticks == '0) ? PERIOD_W'(1) : q_ticks), TICK_W'(0)};
            end
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= t_cmd'(i_cmd.command);
            r_id      <= IW'(i_cmd.timer_id);
            r_snotify <= i_cmd.notify;
            r_prod    <= 64'(i_cmd.period_ms) * 64'(RECIP_10);
        end
        if (r_fire && r_nev < EV_CNT_W'(MAX_EV)) begin
            r_evs[r_nev[2:0]] <= SLOT_W'(r_idx);
            r_evk[r_nev[2:0]] <= r_fkind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_run       <= '0;
            r_per       <= '0;
            r_ntf       <= '0;
            r_idx       <= '0;
            r_nev       <= '0;
            r_eidx      <= '0;
            r_fire      <= 1'b0;
            r_fkind     <= 1'b0;
            o_res.valid <= 1'b0;
        end else begin
            r_fire <= 1'b0;
            if (r_fire && r_nev < EV_CNT_W'(MAX_EV)) begin
                r_nev <= r_nev + 1'b1;
            end
            if (o_res.ready) begin
                o_res.valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_nev  <= '0;
                        r_eidx <= '0;
                        r_idx  <= '0;
                        if (t_cmd'(i_cmd.command) == CMD_TICK) begin
                            r_tick  <= r_tick + 1'b1;
                            r_state <= S_TREAD;
                        end else if (!in_range) begin
                            r_state <= S_EMIT;
                        end else if (t_cmd'(i_cmd.command) == CMD_STOP) begin
                            r_run[IW'(i_cmd.timer_id)] <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_per[r_id] <= (r_cmd == CMD_PERIODIC);
                    r_ntf[r_id] <= r_snotify;
                    r_run[r_id] <= 1'b1;
                    r_state     <= S_EMIT;
                end
                S_TREAD: begin
                    r_state <= r_run[r_idx] ? S_TEVAL : S_NEXT;
                end
                S_TEVAL: begin
                    if (r_per[r_idx]) begin
                        r_state <= S_TDIV;
                    end else begin
                        if (r_tick >= rd_deadline) begin
                            r_run[r_idx] <= 1'b0;
                            r_ntf[r_idx] <= 1'b0;
                            r_fire       <= r_ntf[r_idx];
                            r_fkind      <= 1'b0;
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_TDIV: begin
                    if (div_rsp.done) begin
                        r_fire  <= (div_rsp.rem == '0) && r_ntf[r_idx];
                        r_fkind <= 1'b1;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (32'(r_idx) == NUM_TIMERS - 1) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_TREAD;
                    end
                end
                S_EMIT: begin
                    if (out_free && !r_fire) begin
                        o_res.valid <= 1'b1;
                        r_eidx      <= r_eidx + 1'b1;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free && !r_fire) begin
            o_res.event_valid  <= (r_nev != '0);
            o_res.event_slot   <= (r_nev != '0) ? r_evs[r_eidx] : '0;
            o_res.event_kind   <= (r_nev != '0) ? r_evk[r_eidx] : 1'b0;
            o_res.last         <= emit_last;
            o_res.running_mask <= mask;
            o_res.idle         <= (r_run == '0);
        end
    end

`ifndef SYNTH
    a_nev_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nev <= EV_CNT_W'(MAX_EV))
        else $error("event count overflow");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_TDIV))
        else $error("modulo result outside wait state");
    a_idle_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.idle) |-> (o_res.running_mask == '0))
        else $error("idle with running slots");
    a_emit_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_cmd'(i_cmd.command) == CMD_TICK)) |=> (r_tick == $past(r_tick) + 1'b1))
        else $error("tick count not advanced");
`endif

endmodule
